// ===== hdl/conv_pkg.sv =====
// ----------------------------------------------------------------------------
// conv_pkg: shared types and constants for the convolution mac unit
// payload structs, item kinds, register indexes, controller states
// ----------------------------------------------------------------------------
`default_nettype none
package conv_pkg;

  localparam int unsigned DefMaxHeight   = 64;
  localparam int unsigned DefMaxWidth    = 64;
  localparam int unsigned DefMaxChannels = 4;
  localparam int unsigned DefMaxFilters  = 8;
  localparam int unsigned DefMaxKernel   = 5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;

  typedef enum logic [1:0] {
    KIND_WEIGHT  = 2'd0,
    KIND_BIAS    = 2'd1,
    KIND_SAMPLE  = 2'd2,
    KIND_COMPUTE = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KERNEL   = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_CHANNELS = 3'd3,
    REG_FILTERS  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         row;
    logic [5:0]         col;
    logic [1:0]         channel;
    logic [2:0]         filter;
    logic [2:0]         tap_row;
    logic [2:0]         tap_col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sum;
    logic               saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;   // load bias, clear counters
    logic step;    // issue one tap read and advance
    logic finish;  // saturate into output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;    // current tap is the final one
    logic busy;    // reads or mac still in flight
    logic empty;   // window has no taps
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/conv_ctrl.sv =====
// ----------------------------------------------------------------------------
// conv_ctrl: controller state machine
// sequences one output point through the mac datapath
// ----------------------------------------------------------------------------
`default_nettype none
module conv_ctrl
  import conv_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    req_i,
  input  wire logic    out_stall_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o,
  output logic         busy_o,
  output logic         out_valid_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    busy_o      = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (req_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.empty) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.step = 1'b1;
          if (sts_i.last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!sts_i.busy) begin
          cmd_o.finish = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_start_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> $past(state_q) == ST_IDLE)
    else $error("start not preceded by idle");
  a_finish_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_o)
    else $error("finish not followed by output");
  a_no_step_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !cmd_o.step && !cmd_o.start)
    else $error("step while holding result");
endmodule
`default_nettype wire

// ===== hdl/conv_dp.sv =====
// ----------------------------------------------------------------------------
// conv_dp: storage and mac datapath
// sample, weight and bias memories, tap counters, multiplier and accumulator
// ----------------------------------------------------------------------------
`default_nettype none
module conv_dp
  import conv_pkg::*;
#(
  parameter int unsigned MaxHeight   = DefMaxHeight,
  parameter int unsigned MaxWidth    = DefMaxWidth,
  parameter int unsigned MaxChannels = DefMaxChannels,
  parameter int unsigned MaxFilters  = DefMaxFilters,
  parameter int unsigned MaxKernel   = DefMaxKernel
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   wr_i,
  input  wire logic   req_i,
  input  wire in_item_t item_i,
  input  wire logic [2:0] k_i,
  input  wire logic [6:0] h_i,
  input  wire logic [6:0] w_i,
  input  wire logic [2:0] nc_i,
  input  wire dp_cmd_t cmd_i,
  output dp_sts_t     sts_o,
  output out_item_t   res_o
);
  localparam int unsigned SDepth = MaxHeight * MaxWidth * MaxChannels;
  localparam int unsigned WDepth = MaxKernel * MaxKernel * MaxChannels * MaxFilters;
  localparam int unsigned SAw = (SDepth > 1) ? $clog2(SDepth) : 1;
  localparam int unsigned WAw = (WDepth > 1) ? $clog2(WDepth) : 1;
  localparam int unsigned FAw = (MaxFilters > 1) ? $clog2(MaxFilters) : 1;
  localparam int unsigned AccW = 48;
  localparam int unsigned CoW = 12;

  logic [15:0] smem [SDepth];
  logic [15:0] wmem [WDepth];
  logic [15:0] bmem [MaxFilters];

  // write address computation (in range checks against store bounds)
  logic s_ok, w_ok, b_ok;
  logic [SAw-1:0] s_waddr;
  logic [WAw-1:0] w_waddr;
  always_comb begin
    s_ok = ({26'd0, item_i.row} < 32'(MaxHeight)) && ({26'd0, item_i.col} < 32'(MaxWidth))
        && ({30'd0, item_i.channel} < 32'(MaxChannels));
    w_ok = ({29'd0, item_i.tap_row} < 32'(MaxKernel)) && ({29'd0, item_i.tap_col} < 32'(MaxKernel))
        && ({30'd0, item_i.channel} < 32'(MaxChannels))
        && ({29'd0, item_i.filter} < 32'(MaxFilters));
    b_ok = {29'd0, item_i.filter} < 32'(MaxFilters);
    s_waddr = SAw'(({26'd0, item_i.row} * MaxWidth + {26'd0, item_i.col}) * MaxChannels
        + {30'd0, item_i.channel});
    w_waddr = WAw'((({29'd0, item_i.tap_row} * MaxKernel + {29'd0, item_i.tap_col})
        * MaxChannels + {30'd0, item_i.channel}) * MaxFilters + {29'd0, item_i.filter});
  end

  // request point
  logic [5:0] prow_q, pcol_q;
  logic [2:0] pf_q;
  always_ff @(posedge clk_i) begin
    if (req_i) begin
      prow_q <= item_i.row;
      pcol_q <= item_i.col;
      pf_q   <= item_i.filter;
    end
  end

  // tap counters
  logic [2:0] ti_q, tj_q, ti_d, tj_d;
  logic [1:0] tc_q, tc_d;
  logic [2:0] pad;
  logic signed [CoW-1:0] r_s, c_s;
  logic in_frame;
  logic last_tap, no_taps;
  logic [SAw-1:0] s_raddr;
  logic [WAw-1:0] w_raddr;
  always_comb begin
    pad = (k_i == 3'd0) ? 3'd0 : ((k_i - 3'd1) >> 1);
    r_s = $signed({6'd0, prow_q}) - $signed({9'd0, pad}) + $signed({9'd0, ti_q});
    c_s = $signed({6'd0, pcol_q}) - $signed({9'd0, pad}) + $signed({9'd0, tj_q});
    in_frame = !r_s[CoW-1] && !c_s[CoW-1] && (r_s < $signed({5'd0, h_i}))
        && (c_s < $signed({5'd0, w_i}));
    s_raddr = SAw'((32'(unsigned'(r_s[10:0])) * MaxWidth + 32'(unsigned'(c_s[10:0])))
        * MaxChannels + {30'd0, tc_q});
    w_raddr = WAw'((({29'd0, ti_q} * MaxKernel + {29'd0, tj_q}) * MaxChannels
        + {30'd0, tc_q}) * MaxFilters + {29'd0, pf_q});
    last_tap = (tc_q == 2'(nc_i - 3'd1)) && (tj_q == k_i - 3'd1) && (ti_q == k_i - 3'd1);
    no_taps  = (k_i == 3'd0) || (nc_i == 3'd0);
    tc_d = tc_q;
    tj_d = tj_q;
    ti_d = ti_q;
    if (cmd_i.start) begin
      tc_d = '0;
      tj_d = '0;
      ti_d = '0;
    end else if (cmd_i.step) begin
      if (tc_q == 2'(nc_i - 3'd1)) begin
        tc_d = '0;
        if (tj_q == k_i - 3'd1) begin
          tj_d = '0;
          ti_d = ti_q + 3'd1;
        end else begin
          tj_d = tj_q + 3'd1;
        end
      end else begin
        tc_d = tc_q + 2'd1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    ti_q <= ti_d;
    tj_q <= tj_d;
    tc_q <= tc_d;
  end

  // memories with registered read data
  logic [15:0] s_rd_q, w_rd_q, b_rd_q;
  always_ff @(posedge clk_i) begin
    if (wr_i && item_i.kind == KIND_SAMPLE && s_ok) smem[s_waddr] <= item_i.value;
    s_rd_q <= smem[s_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (wr_i && item_i.kind == KIND_WEIGHT && w_ok) wmem[w_waddr] <= item_i.value;
    w_rd_q <= wmem[w_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (wr_i && item_i.kind == KIND_BIAS && b_ok) bmem[FAw'(item_i.filter)] <= item_i.value;
    b_rd_q <= bmem[FAw'(item_i.filter)];
  end

  // pipeline valids: read stage, product stage
  logic rd_v_q, rd_in_q, pr_v_q;
  logic signed [31:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      pr_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.step;
      pr_v_q <= rd_v_q && rd_in_q;
    end
  end
  always_ff @(posedge clk_i) begin
    rd_in_q <= in_frame;
    prod_q  <= $signed(s_rd_q) * $signed(w_rd_q);
    if (cmd_i.start) begin
      acc_q <= AccW'($signed(b_rd_q)) <<< 8;
    end else if (pr_v_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end
  assign sts_o = '{last: last_tap, busy: rd_v_q || pr_v_q, empty: no_taps};

  // saturate into result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (acc_q > AccW'(64'sh7FFFFFFF)) begin
        res_o <= '{sum: 32'sh7FFFFFFF, saturated: 1'b1};
      end else if (acc_q < -AccW'(64'sh80000000)) begin
        res_o <= '{sum: 32'sh80000000, saturated: 1'b1};
      end else begin
        res_o <= '{sum: acc_q[31:0], saturated: 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/conv2d_same_padding_mac_unit.sv =====
// ----------------------------------------------------------------------------
// conv2d_same_padding_mac_unit: same-padded 2d convolution, one point per request
// stores weights, biases and samples; computes one output point by serial mac
// ----------------------------------------------------------------------------
//
//   channel  direction  payload     handshake
//   in       input      in_item_t   in_valid_i / in_stall_o
//   out      output     out_item_t  out_valid_o / out_stall_i
//   cfg      input      7b data     cfg_we_i / cfg_idx_i
//
// write items (weight, bias, sample) are stored while the block is not busy
// a compute item runs k*k*nc taps, one tap per cycle, through
// one read port per memory and one 16x16 multiplier, plus pipeline drain
// the block takes no new item until the result transfer completes
// stall on the output holds the result register unchanged
// reset clears control only; stores are undefined until written
`default_nettype none
module conv2d_same_padding_mac_unit
  import conv_pkg::*;
#(
  parameter int unsigned MaxHeight   = DefMaxHeight,
  parameter int unsigned MaxWidth    = DefMaxWidth,
  parameter int unsigned MaxChannels = DefMaxChannels,
  parameter int unsigned MaxFilters  = DefMaxFilters,
  parameter int unsigned MaxKernel   = DefMaxKernel
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);
  // configuration registers
  logic [2:0] ks_q, nc_q;
  logic [6:0] fh_q, fw_q;
  logic [3:0] nf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_q <= 3'd3;
      fh_q <= 7'd64;
      fw_q <= 7'd64;
      nc_q <= 3'd1;
      nf_q <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KERNEL:   ks_q <= cfg_data_i[2:0];
        REG_HEIGHT:   fh_q <= cfg_data_i;
        REG_WIDTH:    fw_q <= cfg_data_i;
        REG_CHANNELS: nc_q <= cfg_data_i[2:0];
        REG_FILTERS:  nf_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // capped effective values
  logic [2:0] k_eff, nc_eff;
  logic [6:0] h_eff, w_eff;
  logic [3:0] nf_eff;
  always_comb begin
    k_eff  = (32'(ks_q) > MaxKernel)   ? 3'(MaxKernel)   : ks_q;
    nc_eff = (32'(nc_q) > MaxChannels) ? 3'(MaxChannels) : nc_q;
    h_eff  = (32'(fh_q) > MaxHeight)   ? 7'(MaxHeight)   : fh_q;
    w_eff  = (32'(fw_q) > MaxWidth)    ? 7'(MaxWidth)    : fw_q;
    nf_eff = (32'(nf_q) > MaxFilters)  ? 4'(MaxFilters)  : nf_q;
  end

  logic busy, acc_xfer, req;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign in_stall_o = busy;
  assign acc_xfer   = in_valid_i && !busy;
  // only in-use points start a computation; others are dropped silently
  assign req = acc_xfer && (in_data_i.kind == KIND_COMPUTE)
      && ({1'b0, in_data_i.row} < h_eff) && ({1'b0, in_data_i.col} < w_eff)
      && ({1'b0, in_data_i.filter} < nf_eff);

  conv_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_i       (req),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .out_valid_o (out_valid_o)
  );

  conv_dp #(
    .MaxHeight(MaxHeight), .MaxWidth(MaxWidth), .MaxChannels(MaxChannels),
    .MaxFilters(MaxFilters), .MaxKernel(MaxKernel)
  ) u_dp (
    .clk_i, .rst_ni,
    .wr_i   (acc_xfer),
    .req_i  (req),
    .item_i (in_data_i),
    .k_i    (k_eff),
    .h_i    (h_eff),
    .w_i    (w_eff),
    .nc_i   (nc_eff),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (out_data_o)
  );

  a_busy_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |=> in_stall_o)
    else $error("request did not block input");
  a_sat_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      (out_data_o.sum == 32'sh7FFFFFFF || out_data_o.sum == 32'sh80000000))
    else $error("saturation flag with unclipped sum");
endmodule
`default_nettype wire
